// ===== rtl/alfs_pkg.sv =====
// ----------------------------------------------------------------------------
// alfs_pkg
// Shared widths, codes and helpers of the addressable LED frame serializer.
// ----------------------------------------------------------------------------
package alfs_pkg;

	localparam int MAX_LEDS_DEF = 32;

	localparam int KIND_W    = 2;
	localparam int IDX_W     = 5;
	localparam int COLOR_W   = 8;
	localparam int COUNT_W   = 6;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int BIT_W     = 3;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW       = 2'd3;

	localparam logic [COUNT_W-1:0] LED_COUNT_RST = 6'd0;
	localparam logic [TICK_W-1:0]  ONE_HIGH_RST  = 16'd2;
	localparam logic [TICK_W-1:0]  ZERO_HIGH_RST = 16'd1;
	localparam logic [TICK_W-1:0]  LOW_RST       = 16'd2;

	localparam logic [1:0] COLOR_GREEN = 2'd0;
	localparam logic [1:0] COLOR_RED   = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] blue;
	} row_t;

	function automatic logic [COLOR_W-1:0] byte_of(input row_t row, input logic [1:0] color);
		logic [COLOR_W-1:0] b;
		case (color)
			COLOR_GREEN: b = row.green;
			COLOR_RED:   b = row.red;
			default:     b = row.blue;
		endcase
		return b;
	endfunction

	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

endpackage

// ===== rtl/alfs_item_if.sv =====
// ----------------------------------------------------------------------------
// alfs_item_if
// Input request channel: LED write, frame start or time tick.
// ----------------------------------------------------------------------------
interface alfs_item_if;
	logic                         valid;
	logic                         ready;
	logic [alfs_pkg::KIND_W-1:0]  kind;
	logic [alfs_pkg::IDX_W-1:0]   led_index;
	logic [alfs_pkg::COLOR_W-1:0] red;
	logic [alfs_pkg::COLOR_W-1:0] green;
	logic [alfs_pkg::COLOR_W-1:0] blue;

	modport source (output valid, kind, led_index, red, green, blue, input ready);
	modport sink   (input valid, kind, led_index, red, green, blue, output ready);
endinterface

// ===== rtl/alfs_result_if.sv =====
// ----------------------------------------------------------------------------
// alfs_result_if
// Result channel: line level, busy flag and end-of-frame mark per request.
// ----------------------------------------------------------------------------
interface alfs_result_if;
	logic valid;
	logic ready;
	logic led_line;
	logic busy_res;
	logic frame_done;

	modport source (output valid, led_line, busy_res, frame_done, input ready);
	modport sink   (input valid, led_line, busy_res, frame_done, output ready);
endinterface

// ===== rtl/alfs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// alfs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface alfs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [alfs_pkg::CFG_IDX_W-1:0] index;
	logic [alfs_pkg::TICK_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/addressable_led_frame_serializer.sv =====
// ----------------------------------------------------------------------------
// addressable_led_frame_serializer
// Frame store of GRB colors per LED, serialized MSB first as timed pulses,
// one tick request per waveform time unit.
// ----------------------------------------------------------------------------
// Result: an accepted request's result is registered, valid in the next cycle.
// Throughput: one request per cycle; a new request enters in the cycle the
// previous result is taken, and waits while a result is stalled.
// Reset: registers that have a reset value return to it at once; a clearing
// pass then zeroes every row of the frame store, and no request is accepted
// until it ends (configuration writes are taken throughout).
module addressable_led_frame_serializer #(
	parameter int MAX_LEDS = alfs_pkg::MAX_LEDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	alfs_item_if.sink    items,
	alfs_result_if.source results,
	alfs_cfg_if.sink     cfg
);
	import alfs_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	logic [COUNT_W-1:0] led_count_q;
	logic [TICK_W-1:0]  one_high_q, zero_high_q, low_q;

	logic               sending_q, high_q;
	logic [TICK_W-1:0]  phase_q;
	logic [COLOR_W-1:0] shift_q;
	logic [BIT_W-1:0]   bit_q;
	logic [1:0]         color_q;
	logic [COUNT_W-1:0] led_q;
	row_t               cur_row_q;

	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;

	row_t               mem [MAX_LEDS];
	row_t               rd_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	row_t               mem_wd;

	logic               res_valid_q;
	logic               line_q, busy_q, done_q;

	logic               accept;
	logic               wr_en;
	logic               sending_n, high_n, done_n;
	logic [TICK_W-1:0]  phase_n, phase_inc, dur;
	logic [COLOR_W-1:0] shift_n;
	logic [BIT_W-1:0]   bit_n;
	logic [1:0]         color_n;
	logic [COUNT_W-1:0] led_n;
	row_t               cur_row_n;
	logic               row_wrap;

	assign items.ready = !clr_q && (!res_valid_q || results.ready);
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			one_high_q  <= ONE_HIGH_RST;
			zero_high_q <= ZERO_HIGH_RST;
			low_q       <= LOW_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LED_COUNT: begin
					if (32'(cfg.data[COUNT_W-1:0]) > MAX_LEDS)
						led_count_q <= COUNT_W'(MAX_LEDS);
					else
						led_count_q <= cfg.data[COUNT_W-1:0];
				end
				REG_ONE_HIGH:  one_high_q  <= at_least_one(cfg.data);
				REG_ZERO_HIGH: zero_high_q <= at_least_one(cfg.data);
				REG_LOW:       low_q       <= at_least_one(cfg.data);
				default: ;
			endcase
		end
	end

	// next-state logic of the pulse sequencer
	always_comb begin
		sending_n = sending_q;
		high_n    = high_q;
		phase_n   = phase_q;
		shift_n   = shift_q;
		bit_n     = bit_q;
		color_n   = color_q;
		led_n     = led_q;
		cur_row_n = cur_row_q;
		done_n    = 1'b0;
		wr_en     = 1'b0;
		row_wrap  = 1'b0;
		phase_inc = phase_q + TICK_W'(1);
		dur       = shift_q[COLOR_W-1] ? one_high_q : zero_high_q;
		if (accept) begin
			case (items.kind)
				KIND_WRITE: begin
					if (!sending_q && 32'(items.led_index) < 32'(led_count_q) &&
					    32'(items.led_index) < MAX_LEDS)
						wr_en = 1'b1;
				end
				KIND_START: begin
					if (!sending_q) begin
						if (led_count_q == '0) begin
							done_n = 1'b1;
						end else begin
							led_n     = '0;
							color_n   = COLOR_GREEN;
							bit_n     = '0;
							cur_row_n = rd_q;
							shift_n   = rd_q.green;
							high_n    = 1'b1;
							phase_n   = '0;
							sending_n = 1'b1;
						end
					end
				end
				KIND_TICK: begin
					if (sending_q) begin
						phase_n = phase_inc;
						if (high_q) begin
							if (phase_inc >= dur) begin
								high_n  = 1'b0;
								phase_n = '0;
							end
						end else if (phase_inc >= low_q) begin
							phase_n = '0;
							shift_n = {shift_q[COLOR_W-2:0], 1'b0};
							bit_n   = bit_q + BIT_W'(1);
							if (bit_q == BIT_LAST) begin
								if (color_q == COLOR_BLUE) begin
									row_wrap = 1'b1;
									color_n  = COLOR_GREEN;
									led_n    = led_q + COUNT_W'(1);
								end else begin
									color_n = color_q + 2'd1;
								end
							end
							if (led_n >= led_count_q) begin
								sending_n = 1'b0;
								high_n    = 1'b0;
								led_n     = '0;
								color_n   = COLOR_GREEN;
								bit_n     = '0;
								shift_n   = '0;
								done_n    = 1'b1;
							end else begin
								if (bit_q == BIT_LAST) begin
									if (row_wrap) begin
										cur_row_n = rd_q;
										shift_n   = rd_q.green;
									end else begin
										shift_n = byte_of(cur_row_q, color_n);
									end
								end
								high_n = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			high_q    <= 1'b0;
			phase_q   <= '0;
			shift_q   <= '0;
			bit_q     <= '0;
			color_q   <= COLOR_GREEN;
			led_q     <= '0;
		end else begin
			sending_q <= sending_n;
			high_q    <= high_n;
			phase_q   <= phase_n;
			shift_q   <= shift_n;
			bit_q     <= bit_n;
			color_q   <= color_n;
			led_q     <= led_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_row_q <= cur_row_n;
	end

	// store clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_LEDS - 1))
				clr_q <= 1'b0;
		end
	end

	// frame store: next row is prefetched while sending, row 0 while idle
	assign rd_addr = sending_n ? AW'(led_n + COUNT_W'(1)) : '0;
	assign mem_we  = clr_q || wr_en;
	assign mem_wa  = clr_q ? clr_addr_q : AW'(items.led_index);
	assign mem_wd  = clr_q ? row_t'('0) : row_t'({items.green, items.red, items.blue});

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_we && mem_wa == rd_addr)
			rd_q <= mem_wd;
		else
			rd_q <= mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= sending_n && high_n;
			busy_q <= sending_n;
			done_q <= done_n;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.led_line   = line_q;
	assign results.busy_res   = busy_q;
	assign results.frame_done = done_q;

	// checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |-> !results.busy_res)
		else $error("frame_done reported while busy");

	a_line_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.led_line |-> results.busy_res)
		else $error("line high while not sending");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !items.ready)
		else $error("request accepted during store clear");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> results.valid)
		else $error("accepted request produced no result");

endmodule
